/* rtl/tcw_pkg.sv */
// ============================================================================
// tcw_pkg - text console writer shared definitions
// Transaction types, character codes and default geometry.
// ============================================================================
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int IDX_W  = 11;   // cell_index field width
  localparam int POS_W  = 11;   // cursor_pos field width
  localparam int CELL_W = 16;   // attribute byte over character byte

  localparam logic [7:0] RESET_ATTR  = 8'h07;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic             func;
    logic [7:0]       char_code;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] read_data;
    logic              scrolled;
  } out_item_t;

  // Side effects of one put, from the cursor logic to the controller
  typedef struct packed {
    logic wr_cell;
    logic scroll;
  } put_ctl_t;

endpackage

/* rtl/tcw_ram.sv */
// ============================================================================
// tcw_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tcw_cursor.sv */
// ============================================================================
// tcw_cursor - cursor step logic
// Decodes one put byte, applies wrap and scroll limits, gives the cell
// address under the old cursor and the linear position of the new one.
// ============================================================================
module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  localparam int CW = $clog2(COLUMNS + 1),
  localparam int RW = $clog2(ROWS + 1),
  localparam int AW = $clog2(ROWS * COLUMNS)
) (
  input  logic [RW-1:0]            cur_row,
  input  logic [CW-1:0]            cur_col,
  input  logic [7:0]               char_code,
  output logic [AW-1:0]            cell_addr,
  output logic [RW-1:0]            nxt_row,
  output logic [CW-1:0]            nxt_col,
  output logic [tcw_pkg::POS_W-1:0] nxt_pos,
  output tcw_pkg::put_ctl_t        ctl
);

  localparam int PW = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;

  logic [CW-1:0] col_a;
  logic [RW-1:0] row_a;
  logic [CW-1:0] col_b;
  logic [RW-1:0] row_b;
  logic          wr;
  logic          scr;
  logic [PW-1:0] lin_cur;
  logic [PW-1:0] lin_nxt;

  always_comb begin
    col_a = cur_col;
    row_a = cur_row;
    wr    = 1'b0;
    if (char_code == tcw_pkg::CH_LF) begin
      col_a = '0;
      row_a = cur_row + RW'(1);
    end else if (char_code == tcw_pkg::CH_CR) begin
      col_a = '0;
    end else if (char_code == tcw_pkg::CH_BS || char_code == tcw_pkg::CH_DEL) begin
      if (cur_col != '0) begin
        col_a = cur_col - CW'(1);
      end
    end else if (char_code inside {[tcw_pkg::CH_PRINT_LO:tcw_pkg::CH_PRINT_HI]}) begin
      wr    = 1'b1;
      col_a = cur_col + CW'(1);
    end

    // wrap at the last column
    col_b = col_a;
    row_b = row_a;
    if (col_a >= CW'(COLUMNS)) begin
      col_b = '0;
      row_b = row_a + RW'(1);
    end

    // past the last row: scroll, cursor stays on the bottom row
    scr     = 1'b0;
    nxt_row = row_b;
    if (row_b >= RW'(ROWS)) begin
      scr     = 1'b1;
      nxt_row = RW'(ROWS - 1);
    end
    nxt_col = col_b;
  end

  assign lin_cur   = PW'(cur_row) * PW'(COLUMNS) + PW'(cur_col);
  assign lin_nxt   = PW'(nxt_row) * PW'(COLUMNS) + PW'(nxt_col);
  assign cell_addr = lin_cur[AW-1:0];
  assign nxt_pos   = lin_nxt[tcw_pkg::POS_W-1:0];

  assign ctl.wr_cell = wr;
  assign ctl.scroll  = scr;

endmodule

/* rtl/text_console_writer_core.sv */
// ============================================================================
// text_console_writer_core - text-mode console engine
// Screen store in one RAM, row/column cursor, put and read transactions.
// ============================================================================
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in_      | in        | in_valid / in_stall    | tcw_pkg::in_item_t
//  out_     | out       | out_valid / out_stall  | tcw_pkg::out_item_t
//  cfg_     | in        | cfg_wr_en              | text attribute byte
//
//  A put's result is registered at acceptance.
//  A read waits in ST_READ on the registered read port of the screen RAM.
//  A put that scrolls blocks input while the rows are shifted up, with
//  one row-shift copy per cycle through the RAM, and then while the
//  bottom row is blanked one cell per cycle.
//  After reset a clearing pass over all ROWS*COLUMNS cells fills
//  the store with blanks; input is stalled, configuration writes are taken.
//  Input is also stalled while the output register holds an untaken result.
//
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  // result transactions
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int IW    = (AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W;

  typedef enum logic [2:0] {
    ST_CLEAR,   // post-reset blanking pass
    ST_IDLE,    // ready for a transaction
    ST_READ,    // waiting on RAM read data
    ST_COPY,    // scroll: shift rows up
    ST_BLANK    // scroll: blank bottom row
  } state_t;

  state_t state_r, state_nxt;

  // cursor and configuration
  logic [RW-1:0]             cur_row_r, cur_row_nxt;
  logic [CW-1:0]             cur_col_r, cur_col_nxt;
  logic [tcw_pkg::POS_W-1:0] cur_pos_r, cur_pos_nxt;
  logic [7:0]                attr_r, attr_nxt;
  logic [7:0]                blank_attr_r, blank_attr_nxt;

  // sweep pointer (clear, copy source, blank), copy write side
  logic [SW-1:0]             src_r, src_nxt;
  logic [AW-1:0]             dst_r, dst_nxt;
  logic                      pend_r, pend_nxt;
  logic                      in_range_r, in_range_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t        out_data_r, out_data_nxt;

  // RAM port signals
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  // cursor step
  logic [AW-1:0]             cell_addr;
  logic [RW-1:0]             step_row;
  logic [CW-1:0]             step_col;
  logic [tcw_pkg::POS_W-1:0] step_pos;
  tcw_pkg::put_ctl_t         step_ctl;

  logic                      out_free;
  logic                      in_fire;
  logic                      put_fire;
  logic                      read_fire;
  logic [IW-1:0]             idx_ext;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .cur_row   (cur_row_r),
    .cur_col   (cur_col_r),
    .char_code (in_data.char_code),
    .cell_addr (cell_addr),
    .nxt_row   (step_row),
    .nxt_col   (step_col),
    .nxt_pos   (step_pos),
    .ctl       (step_ctl)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake: one transaction in flight, output slot must be free or
  // emptying this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_fire   = in_valid && !in_stall;
  assign put_fire  = in_fire && (in_data.func == tcw_pkg::FUNC_PUT);
  assign read_fire = in_fire && (in_data.func == tcw_pkg::FUNC_READ);
  assign idx_ext   = IW'(in_data.cell_index);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = {attr_r, in_data.char_code};
    ram_raddr = idx_ext[AW-1:0];
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = src_r[AW-1:0];
        ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_SPACE};
      end
      ST_IDLE: begin
        ram_we = put_fire && step_ctl.wr_cell;
      end
      ST_COPY: begin
        // read address runs COLUMNS + 1 cells ahead of the write; addresses never meet
        ram_raddr = src_r[AW-1:0];
        ram_we    = pend_r;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = src_r[AW-1:0];
        ram_wdata = {blank_attr_r, tcw_pkg::CHAR_SPACE};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    cur_pos_nxt    = cur_pos_r;
    attr_nxt       = cfg_wr_en ? cfg_wr_data : attr_r;
    blank_attr_nxt = blank_attr_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    pend_nxt       = 1'b0;
    in_range_nxt   = in_range_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    case (state_r)
      ST_CLEAR: begin
        src_nxt = src_r + SW'(1);
        if (src_r == SW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (put_fire) begin
          cur_row_nxt             = step_row;
          cur_col_nxt             = step_col;
          cur_pos_nxt             = step_pos;
          out_valid_nxt           = 1'b1;
          out_data_nxt.cursor_pos = step_pos;
          out_data_nxt.read_data  = '0;
          out_data_nxt.scrolled   = step_ctl.scroll;
          if (step_ctl.scroll) begin
            // blank colour is taken at the put that scrolls
            blank_attr_nxt = attr_r;
            src_nxt        = SW'(COLUMNS);
            state_nxt      = ST_COPY;
          end
        end else if (read_fire) begin
          in_range_nxt = idx_ext < IW'(CELLS);
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.cursor_pos = cur_pos_r;
        out_data_nxt.read_data  = in_range_r ? ram_rdata : '0;
        out_data_nxt.scrolled   = 1'b0;
        state_nxt               = ST_IDLE;
      end
      ST_COPY: begin
        if (src_r < SW'(CELLS)) begin
          pend_nxt = 1'b1;
          dst_nxt  = AW'(src_r - SW'(COLUMNS));
          src_nxt  = src_r + SW'(1);
        end else begin
          // last copy write lands this cycle
          src_nxt   = SW'((ROWS - 1) * COLUMNS);
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK: begin
        src_nxt = src_r + SW'(1);
        if (src_r == SW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cur_pos_r   <= '0;
      attr_r      <= tcw_pkg::RESET_ATTR;
      src_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_pos_r    <= cur_pos_nxt;
      attr_r       <= attr_nxt;
      blank_attr_r <= blank_attr_nxt;
      src_r        <= src_nxt;
      dst_r        <= dst_nxt;
      pend_r       <= pend_nxt;
      in_range_r   <= in_range_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // cursor stays on screen whenever a transaction may be taken
  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cur_col_r < CW'(COLUMNS)) && (cur_row_r < RW'(ROWS)))
    else $error("cursor outside screen");

  // a scrolling put leaves the cursor on the bottom row and starts the copy
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (put_fire && step_ctl.scroll) |=> (cur_row_r == RW'(ROWS - 1)) && (state_r == ST_COPY))
    else $error("scroll did not settle cursor on bottom row");

  // in idle, the store is written only by an accepted printable put
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && ram_we) |-> put_fire)
    else $error("stray screen write in idle");

  // read results always carry a clear scrolled flag
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid_r && !out_data_r.scrolled)
    else $error("read result malformed");

endmodule
